// ===== rtl/assert_macros.svh =====
// Assertion macros used by the channel allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CIDA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CIDA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cida_pkg.sv =====
// Types and constants shared by the channel allocator modules.
`timescale 1ns / 1ps

package cida_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ATTACH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_NO_CHAN = 2'd3
    } st_t;

    // Source of the result handle.
    typedef enum logic [1:0] {
        HSEL_ZERO,
        HSEL_ALLOC,
        HSEL_SEARCH
    } hsel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_SEARCH,
        S_FINISH
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic  in_ready;
        logic  stack_rd;
        logic  alloc_commit;
        logic  free_commit;
        logic  search_init;
        logic  search_step;
        logic  set_res;
        st_t   res_status;
        hsel_t res_hsel;
        logic  load_out;
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic in_valid;
        cmd_t cmd;
        logic stack_empty;
        logic stack_full;
        logic hdl_range_err;
        logic hdl_valid;
        logic match;
        logic search_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/cida_ifs.sv =====
// Request and response channel interfaces of the channel allocator.
`timescale 1ns / 1ps

interface cida_req_if;
    logic                          valid;
    logic                          ready;
    logic [cida_pkg::CMD_W-1:0]    command;
    logic [cida_pkg::KEY_W-1:0]    key;
    logic [cida_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, output command, output key, output handle, input ready);
    modport sink   (input valid, input command, input key, input handle, output ready);
endinterface

interface cida_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cida_pkg::STATUS_W-1:0] status;
    logic [cida_pkg::HANDLE_W-1:0] handle_out;

    modport source (output valid, output status, output handle_out, input ready);
    modport sink   (input valid, input status, input handle_out, output ready);
endinterface

// ===== rtl/channel_id_allocator_with_key_lookup.sv =====
// Top level of the channel number allocator with key lookup.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Hands out channel numbers from a pool of CHANNELS, each tagged with a key.
// Channel req carries command (allocate, free, attach), key and handle;
// channel rsp returns one item per request with status and handle_out.
// Both channels use valid/ready; an item moves on an edge with both high.
// Free numbers live on a LIFO stack; after reset channel 0 comes out first.
// Path, request accept edge to response valid:
//   free or unknown command: dispatch, then finish loads the output register
//   allocate: dispatch, one registered read of the free stack, then finish
//   attach: dispatch, then a scan of the key table, a RAM with one read
//   port, scanned one entry per cycle from channel 0 up, stopping at a match.
// One request is worked at a time; req.ready rises again the cycle after
// the result is placed in the output register, so a new request is taken
// while a response still waits there. A stalled rsp holds the response
// and parks the block with the next result until rsp.ready.
// Reset clears all valid bits and refills the stack at once (no sweep);
// req.ready is high the first cycle after reset is released.

module channel_id_allocator_with_key_lookup #(
    parameter int CHANNELS = 16
) (
    input logic        clk,
    input logic        rst_n,
    cida_req_if.sink   req,
    cida_rsp_if.source rsp
);
    import cida_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    // Sequence each request
    cida_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Hold the pool state and the response register
    cida_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

    // A push must never overflow the stack or free a dead channel.
    `CIDA_ASSERT_NOW(a_free_legal, clk, rst_n, ctl.free_commit, !stat.stack_full && stat.hdl_valid && !stat.hdl_range_err, "free committed on illegal state")
    // A pop must never run on an empty stack.
    `CIDA_ASSERT_NOW(a_alloc_legal, clk, rst_n, ctl.alloc_commit, !stat.stack_empty, "allocate committed on empty stack")
    // Never overwrite a response that has not been taken.
    `CIDA_ASSERT_NOW(a_no_overwrite, clk, rst_n, ctl.load_out, stat.out_free, "response overwritten")
    // Only one request in flight: ready drops right after an accept.
    `CIDA_ASSERT_NEXT(a_one_item, clk, rst_n, req.valid && req.ready, !req.ready, "second request accepted")

endmodule

// ===== rtl/cida_ctrl.sv =====
// Controller state machine of the channel allocator.
`timescale 1ns / 1ps

module cida_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  cida_pkg::stat_t stat,
    output cida_pkg::ctl_t  ctl
);
    import cida_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_ALLOC:
                    begin
                        if (stat.stack_empty)
                        begin
                            ctl.set_res    = 1'b1;
                            ctl.res_status = ST_NO_FREE;
                            ctl.res_hsel   = HSEL_ZERO;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            ctl.stack_rd = 1'b1;
                            state_next   = S_ALLOC;
                        end
                    end
                    CMD_FREE:
                    begin
                        ctl.set_res  = 1'b1;
                        ctl.res_hsel = HSEL_ZERO;
                        state_next   = S_FINISH;
                        if (stat.hdl_range_err)
                        begin
                            ctl.res_status = ST_RANGE;
                        end
                        else if (!stat.hdl_valid)
                        begin
                            ctl.res_status = ST_NO_CHAN;
                        end
                        else if (stat.stack_full)
                        begin
                            ctl.res_status = ST_NO_FREE;
                        end
                        else
                        begin
                            ctl.free_commit = 1'b1;
                            ctl.res_status  = ST_OK;
                        end
                    end
                    CMD_ATTACH:
                    begin
                        ctl.search_init = 1'b1;
                        state_next      = S_SEARCH;
                    end
                    default:
                    begin
                        ctl.set_res    = 1'b1;
                        ctl.res_status = ST_NO_CHAN;
                        ctl.res_hsel   = HSEL_ZERO;
                        state_next     = S_FINISH;
                    end
                endcase
            end
            S_ALLOC:
            begin
                ctl.alloc_commit = 1'b1;
                ctl.set_res      = 1'b1;
                ctl.res_status   = ST_OK;
                ctl.res_hsel     = HSEL_ALLOC;
                state_next       = S_FINISH;
            end
            S_SEARCH:
            begin
                if (stat.match)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ST_OK;
                    ctl.res_hsel   = HSEL_SEARCH;
                    state_next     = S_FINISH;
                end
                else if (stat.search_last)
                begin
                    ctl.set_res    = 1'b1;
                    ctl.res_status = ST_NO_CHAN;
                    ctl.res_hsel   = HSEL_ZERO;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctl.search_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cida_dp.sv =====
// Datapath of the channel allocator: free stack, key table, valid bits, result.
`timescale 1ns / 1ps

module cida_dp #(
    parameter int CHANNELS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cida_pkg::ctl_t  ctl,
    output cida_pkg::stat_t stat,
    cida_req_if.sink        req,
    cida_rsp_if.source      rsp
);
    import cida_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [CW-1:0]       COUNT_FULL   = CW'(CHANNELS);
    localparam logic [AW-1:0]       IDX_LAST     = AW'(CHANNELS - 1);
    localparam logic [HANDLE_W:0]   HANDLE_LIMIT = (HANDLE_W + 1)'(CHANNELS);
    localparam logic [HANDLE_W-1:0] TOP_NUMBER   = HANDLE_W'(CHANNELS - 1);

    // Captured item
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // Pool state
    logic [CW-1:0]       count_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic [CHANNELS-1:0] stk_wr_reg;
    logic [HANDLE_W-1:0] stack_mem [CHANNELS];
    logic [KEY_W-1:0]    key_mem   [CHANNELS];

    // Read data
    logic [HANDLE_W-1:0] stk_q_reg;
    logic                stk_wr_q_reg;
    logic [HANDLE_W-1:0] stk_def_q_reg;
    logic [KEY_W-1:0]    key_q_reg;
    logic [AW-1:0]       idx_reg;

    // Result and output
    st_t                 res_status_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic                out_valid_reg;
    st_t                 out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;

    logic [CW-1:0]       count_m1;
    logic [AW-1:0]       pop_idx;
    logic [AW-1:0]       push_idx;
    logic [AW-1:0]       hdl_idx;
    logic [HANDLE_W-1:0] alloc_ch;
    logic [AW-1:0]       alloc_idx;
    logic [AW-1:0]       rd_next_idx;
    logic [AW-1:0]       key_rd_addr;
    logic                capture;

    assign capture     = ctl.in_ready && req.valid;
    assign count_m1    = count_reg - CW'(1);
    assign pop_idx     = count_m1[AW-1:0];
    assign push_idx    = count_reg[AW-1:0];
    assign hdl_idx     = handle_reg[AW-1:0];
    // An entry never pushed still holds its reset number.
    assign alloc_ch    = stk_wr_q_reg ? stk_q_reg : stk_def_q_reg;
    assign alloc_idx   = alloc_ch[AW-1:0];
    assign rd_next_idx = (idx_reg == IDX_LAST) ? idx_reg : idx_reg + AW'(1);
    assign key_rd_addr = ctl.search_init ? '0 : rd_next_idx;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cmd_reg    <= cmd_t'(req.command);
            key_reg    <= req.key;
            handle_reg <= req.handle;
        end
    end

    // Memories: the key of a freed channel is left in place; the scan may read
    // it, but its valid bit stays clear until the channel is allocated and written anew.
    always_ff @(posedge clk)
    begin
        if (ctl.free_commit)
        begin
            stack_mem[push_idx] <= handle_reg;
        end
        if (ctl.stack_rd)
        begin
            stk_q_reg     <= stack_mem[pop_idx];
            stk_wr_q_reg  <= stk_wr_reg[pop_idx];
            stk_def_q_reg <= TOP_NUMBER - HANDLE_W'(pop_idx);
        end
        if (ctl.alloc_commit)
        begin
            key_mem[alloc_idx] <= key_reg;
        end
        key_q_reg <= key_mem[key_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_FULL;
            valid_reg  <= '0;
            stk_wr_reg <= '0;
        end
        else
        begin
            if (ctl.alloc_commit)
            begin
                count_reg            <= count_m1;
                valid_reg[alloc_idx] <= 1'b1;
            end
            else if (ctl.free_commit)
            begin
                count_reg            <= count_reg + CW'(1);
                valid_reg[hdl_idx]   <= 1'b0;
                stk_wr_reg[push_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.search_init)
        begin
            idx_reg <= '0;
        end
        else if (ctl.search_step)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (ctl.set_res)
        begin
            res_status_reg <= ctl.res_status;
            case (ctl.res_hsel)
                HSEL_ALLOC:  res_handle_reg <= alloc_ch;
                HSEL_SEARCH: res_handle_reg <= HANDLE_W'(idx_reg);
                default:     res_handle_reg <= '0;
            endcase
        end
        if (ctl.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign req.ready      = ctl.in_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;

    assign stat.in_valid      = req.valid;
    assign stat.cmd           = cmd_reg;
    assign stat.stack_empty   = (count_reg == '0);
    assign stat.stack_full    = (count_reg >= COUNT_FULL);
    assign stat.hdl_range_err = ({1'b0, handle_reg} >= HANDLE_LIMIT);
    assign stat.hdl_valid     = valid_reg[hdl_idx];
    assign stat.match         = valid_reg[idx_reg] && (key_q_reg == key_reg);
    assign stat.search_last   = (idx_reg == IDX_LAST);
    assign stat.out_free      = !out_valid_reg || rsp.ready;

endmodule
